>>> hw/rtl/dual_stack_queue_engine_top_defines.svh
// Assertion macros for the dual stack/queue engine checker.
`ifndef DUAL_STACK_QUEUE_ENGINE_TOP_DEFINES_SVH
`define DUAL_STACK_QUEUE_ENGINE_TOP_DEFINES_SVH

// Assert a property on an explicit clock and active-low reset.
`define DSQE_ASSERT_ON(label, ck, rn, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("dsqe assertion failed");

// Assert a property on the local clk and rst_n.
`define DSQE_ASSERT(label, prop) `DSQE_ASSERT_ON(label, clk, rst_n, prop)

`endif

>>> hw/rtl/dsqe_pkg.sv
// Types and constants shared by the dual stack/queue engine.
package dsqe_pkg;

    localparam int OP_W      = 3;
    localparam int VAL_W     = 32;
    localparam int KIND_W    = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_DUMP  = 3'd4
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NOTICE,
        S_DATA
    } state_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        logic  start_walk;
        logic  walk_single;
        logic  set_notice;
        kind_t notice_kind;
        logic  emit_notice;
        logic  emit_data;
    } dsqe_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic walk_last;
        logic out_free;
    } dsqe_status_t;

endpackage

>>> hw/rtl/dsqe_ctrl.sv
// Controller state machine of the dual stack/queue engine.
module dsqe_ctrl
    import dsqe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    input  logic [OP_W-1:0]    op,
    input  dsqe_status_t       status,
    output dsqe_cmd_t          cmd,
    output logic               s_ready
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    if (op == OP_PUSH)
                    begin
                        if (status.full)
                        begin
                            cmd.set_notice  = 1'b1;
                            cmd.notice_kind = KIND_OVERFLOW;
                            state_next      = S_NOTICE;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (status.empty)
                    begin
                        cmd.set_notice  = 1'b1;
                        cmd.notice_kind = KIND_EMPTY;
                        state_next      = S_NOTICE;
                    end
                    else
                    begin
                        case (op)
                            OP_POP:
                            begin
                                cmd.start_walk  = 1'b1;
                                cmd.walk_single = 1'b1;
                                cmd.pop         = 1'b1;
                                state_next      = S_DATA;
                            end
                            OP_PEEK:
                            begin
                                cmd.start_walk  = 1'b1;
                                cmd.walk_single = 1'b1;
                                state_next      = S_DATA;
                            end
                            OP_CLEAR:
                            begin
                                cmd.clear = 1'b1;
                            end
                            default:
                            begin
                                cmd.start_walk = 1'b1;
                                state_next     = S_DATA;
                            end
                        endcase
                    end
                end
            end
            S_NOTICE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_notice = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DATA:
            begin
                if (status.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    if (status.walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/dsqe_datapath.sv
// Datapath of the dual stack/queue engine: entry memories, pointers and output register.
module dsqe_datapath
    import dsqe_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    target,
    input  logic signed [VAL_W-1:0] push_value,
    input  dsqe_cmd_t               cmd,
    output dsqe_status_t            status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [M_TDATA_W-1:0]    out_data,
    output logic [M_TUSER_W-1:0]    out_user,
    output logic                    out_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [VAL_W-1:0] stack_mem [DEPTH];
    logic [VAL_W-1:0] queue_mem [DEPTH];

    logic [CW-1:0]    stack_count_reg;
    logic [CW-1:0]    queue_count_reg;
    logic [AW-1:0]    queue_head_reg;
    logic [AW-1:0]    queue_tail_reg;
    logic             tgt_reg;
    logic [AW-1:0]    walk_idx_reg;
    logic [CW-1:0]    remain_reg;
    kind_t            notice_kind_reg;
    logic [VAL_W-1:0] stack_rd_reg;
    logic [VAL_W-1:0] queue_rd_reg;
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_data_reg;
    kind_t            out_kind_reg;
    logic             out_src_reg;
    logic             out_last_reg;

    logic [CW-1:0]    sel_count;
    logic [CW-1:0]    stack_top_full;
    logic [AW-1:0]    stack_top;
    logic             walk_tgt;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    idx_next;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        logic [AW-1:0] res;
        res = (idx == LAST_IDX) ? '0 : idx + AW'(1);
        return res;
    endfunction

    assign sel_count      = target ? queue_count_reg : stack_count_reg;
    assign stack_top_full = stack_count_reg - CW'(1);
    assign stack_top      = stack_top_full[AW-1:0];

    assign status.empty     = (sel_count == '0);
    assign status.full      = (sel_count == CW'(DEPTH));
    assign status.walk_last = (remain_reg == CW'(1));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign walk_tgt = cmd.start_walk ? target : tgt_reg;
    assign rd_en    = cmd.start_walk || (cmd.emit_data && !status.walk_last);
    assign rd_addr  = cmd.start_walk ? (target ? queue_head_reg : stack_top) : walk_idx_reg;
    assign idx_next = walk_tgt ? wrap_inc(rd_addr) : rd_addr - AW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.push && !target)
        begin
            stack_mem[stack_count_reg[AW-1:0]] <= push_value;
        end
        if (rd_en)
        begin
            stack_rd_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && target)
        begin
            queue_mem[queue_tail_reg] <= push_value;
        end
        if (rd_en)
        begin
            queue_rd_reg <= queue_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= '0;
            queue_count_reg <= '0;
            queue_head_reg  <= '0;
            queue_tail_reg  <= '0;
            tgt_reg         <= 1'b0;
            walk_idx_reg    <= '0;
            remain_reg      <= '0;
            notice_kind_reg <= KIND_DATA;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                if (target)
                begin
                    queue_count_reg <= queue_count_reg + CW'(1);
                    queue_tail_reg  <= wrap_inc(queue_tail_reg);
                end
                else
                begin
                    stack_count_reg <= stack_count_reg + CW'(1);
                end
            end
            if (cmd.pop)
            begin
                if (target)
                begin
                    queue_count_reg <= queue_count_reg - CW'(1);
                    queue_head_reg  <= wrap_inc(queue_head_reg);
                end
                else
                begin
                    stack_count_reg <= stack_count_reg - CW'(1);
                end
            end
            if (cmd.clear)
            begin
                if (target)
                begin
                    queue_count_reg <= '0;
                    queue_head_reg  <= '0;
                    queue_tail_reg  <= '0;
                end
                else
                begin
                    stack_count_reg <= '0;
                end
            end
            if (cmd.set_notice)
            begin
                tgt_reg         <= target;
                notice_kind_reg <= cmd.notice_kind;
            end
            if (cmd.start_walk)
            begin
                tgt_reg      <= target;
                remain_reg   <= cmd.walk_single ? CW'(1) : sel_count;
                walk_idx_reg <= idx_next;
            end
            else if (cmd.emit_data && !status.walk_last)
            begin
                remain_reg   <= remain_reg - CW'(1);
                walk_idx_reg <= idx_next;
            end
            if (cmd.emit_data || cmd.emit_notice)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_data)
        begin
            out_data_reg <= tgt_reg ? queue_rd_reg : stack_rd_reg;
            out_kind_reg <= KIND_DATA;
            out_src_reg  <= tgt_reg;
            out_last_reg <= status.walk_last;
        end
        else if (cmd.emit_notice)
        begin
            out_data_reg <= '0;
            out_kind_reg <= notice_kind_reg;
            out_src_reg  <= tgt_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = {out_kind_reg, out_src_reg};
    assign out_last  = out_last_reg;

endmodule

>>> hw/rtl/dual_stack_queue_engine_top.sv
// Top level of the dual stack/queue engine.
// One LIFO stack and one FIFO queue of signed 32-bit entries, DEPTH entries each.
// Input stream s_axis: tuser selects the structure (0 stack, 1 queue); tdata carries
// the operation (push, pop, peek, clear, dump) and the value to push.
// Output stream m_axis: tdata is the entry value, tuser gives source and kind
// (data, empty notice, overflow notice), tlast marks the final result of a transaction.
// Push and clear are accepted back to back unless they raise a notice.
// Pop and peek pass through the registered memory read, then the output register;
// a notice through its kind register, then the output register. The next input is
// taken after that. A dump of N entries sends one entry per cycle while the sink is
// ready, read through the entry memory's single read port.
// Reset empties both structures at once; entry memories are not cleared and
// no entry is read before it is written.
// When the sink stalls, the output register holds its result and a dump
// pauses; a push or clear is still accepted while a result waits.
module dual_stack_queue_engine_top
    import dsqe_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // op[2:0], push_value[34:3], zero pad
    input  logic                 s_axis_tuser,   // target
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // item_value[31:0]
    output logic [M_TUSER_W-1:0] m_axis_tuser,   // source[0], kind[2:1]
    output logic                 m_axis_tlast
);

    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] push_value;
    dsqe_cmd_t               cmd;
    dsqe_status_t            status;

    assign op         = s_axis_tdata[OP_W-1:0];
    assign push_value = s_axis_tdata[OP_W +: VAL_W];

    dsqe_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .op      (op),
        .status  (status),
        .cmd     (cmd),
        .s_ready (s_axis_tready)
    );

    dsqe_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .target     (s_axis_tuser),
        .push_value (push_value),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

>>> hw/rtl/dsqe_checker.sv
// Port-level checks for the dual stack/queue engine, bound to the top level.
`include "dual_stack_queue_engine_top_defines.svh"

module dsqe_checker
    import dsqe_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser,
    input logic                 m_axis_tlast
);

    `DSQE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    `DSQE_ASSERT(a_notice_zero, m_axis_tvalid && m_axis_tuser[2:1] != KIND_DATA |-> m_axis_tdata == '0 && m_axis_tlast)
    `DSQE_ASSERT(a_busy_after_read, s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] != OP_PUSH && s_axis_tdata[2:0] != OP_CLEAR |=> !s_axis_tready)
    `DSQE_ASSERT(a_dump_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)

endmodule

bind dual_stack_queue_engine_top dsqe_checker u_dsqe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
